// ===== src/sliding_window_event_rate_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window event rate block
// Concurrent property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EVENT_RATE_ASSERT_SVH
`define SLIDING_WINDOW_EVENT_RATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWER_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWER_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/swer_pkg.sv =====
// ----------------------------------------------------------------------------
// swer_pkg
// Widths, constants and register map of the sliding window event rate block.
// ----------------------------------------------------------------------------
package swer_pkg;

    // Ring store of timestamps; the depth must be a power of two.
    localparam int FIFO_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int TIME_W  = 63;
    localparam int LIMIT_W = 40;
    localparam int RATE_W  = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64'd5001000000);

    // floor(count * 16 / 5) is computed as (count * 52429) >> 14, which is
    // exact for every count the store can hold.
    localparam int                RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_FIFTH = 16'd52429;
    localparam int                RECIP_SHIFT = 14;
    localparam int                PROD_W      = CNT_W + RECIP_W;

    // Configuration port: registers at 8-byte spacing.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam logic REG_WINDOW_LIMIT = 1'b0;

endpackage

// ===== src/sliding_window_event_rate.sv =====
// ----------------------------------------------------------------------------
// sliding_window_event_rate
// Counts capture events inside a sliding time window and reports the rate.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Carries
//  s_        in         s_valid/s_ready    capture_time_ns
//  m_        out        m_valid/m_ready    kept_count, rate_q4, overflow
//  APB       in/out     psel/penable       window_limit_ns at byte address 0
//
//  An item runs ST_READ and ST_CMP, repeated for each stamp dropped from the
//  head of the window, then ST_DONE once a head stamp is kept or the window
//  ends up empty. Each head check is a read of the single stamp memory read
//  port followed by one 64-bit subtract and compare. Reset is synchronous and
//  active low. s_ready is high only while no item is in progress, so the
//  next item waits until the previous result is registered. A result
//  waiting on m_ready does not hold back acceptance of the next item, but
//  that item then waits in its last state until the result register frees.
// ----------------------------------------------------------------------------
module sliding_window_event_rate
    import swer_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_W-1:0]     s_capture_time_ns,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CNT_W-1:0]      m_kept_count,
    output logic [RATE_W-1:0]     m_rate_q4,
    output logic                  m_overflow,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic                 m_valid_reg, m_valid_next;

    logic [TIME_W-1:0]    now_reg;
    logic                 ovf_reg;
    logic [TIME_W-1:0]    rd_data_reg;
    logic [CNT_W-1:0]     kept_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic                 m_ovf_reg;

    logic [TIME_W-1:0]    stamp_mem [FIFO_DEPTH];

    logic                 accept;
    logic                 full;
    logic [ADDR_W-1:0]    tail;
    logic                 cfg_write;
    logic                 out_free;
    logic [TIME_W:0]      diff;
    logic                 keep_head;
    logic [PROD_W-1:0]    rate_prod;

    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    // When full the oldest stamp goes, so the new one lands where the head was.
    assign tail      = full ? head_reg : head_reg + count_reg[ADDR_W-1:0];
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_valid_reg || m_ready;

    // Shared subtract and compare: a borrow means the stored stamp is later
    // than now, which also keeps it.
    assign diff      = {1'b0, now_reg} - {1'b0, rd_data_reg};
    assign keep_head = diff[TIME_W] ||
                       (diff[TIME_W-1:0] < {{(TIME_W-LIMIT_W){1'b0}}, limit_reg});

    assign rate_prod = PROD_W'(count_reg) * PROD_W'(RECIP_FIFTH);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        limit_next   = limit_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_write && (paddr[3] == REG_WINDOW_LIMIT)) begin
            limit_next = pwdata[LIMIT_W-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (full) begin
                        head_next = head_reg + ADDR_W'(1);
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (keep_head) begin
                    state_next = ST_DONE;
                end else begin
                    head_next  = head_reg + ADDR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    state_next = (count_reg == CNT_W'(1)) ? ST_DONE : ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item payload and result registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg <= s_capture_time_ns;
            ovf_reg <= full;
        end
        if (state_reg == ST_DONE && out_free) begin
            kept_reg  <= count_reg;
            rate_reg  <= rate_prod[RECIP_SHIFT +: RATE_W];
            m_ovf_reg <= ovf_reg;
        end
    end

    // Stamp memory: one write port, one registered read port at the head.
    always_ff @(posedge aclk) begin
        if (accept) begin
            stamp_mem[tail] <= s_capture_time_ns;
        end
        rd_data_reg <= stamp_mem[head_reg];
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_kept_count = kept_reg;
    assign m_rate_q4    = rate_reg;
    assign m_overflow   = m_ovf_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_WINDOW_LIMIT) ?
                    {{(APB_DATA_W-LIMIT_W){1'b0}}, limit_reg} : '0;

endmodule

// ===== src/swer_chk.sv =====
// ----------------------------------------------------------------------------
// swer_chk
// Port-level checks on the sliding window event rate block, bound to its top.
// ----------------------------------------------------------------------------
`include "sliding_window_event_rate_assert.svh"

module swer_chk
    import swer_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CNT_W-1:0]  m_kept_count,
    input logic [RATE_W-1:0] m_rate_q4,
    input logic              m_overflow
);

    logic [RATE_W+3:0] rate_x5;
    logic [RATE_W+3:0] count_x16;

    assign rate_x5   = (RATE_W+4)'(m_rate_q4) * (RATE_W+4)'(5);
    assign count_x16 = (RATE_W+4)'(m_kept_count) << 4;

    // A stalled result item keeps its value.
    `SWER_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_kept_count) && $stable(m_rate_q4) && $stable(m_overflow),
        "result item changed while stalled")

    // One item at a time: the block is busy right after an acceptance.
    `SWER_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready,
        "input accepted again while an item was in progress")

    `SWER_ASSERT_IMP(a_count_range, aclk, aresetn, m_valid,
        m_kept_count <= CNT_W'(FIFO_DEPTH), "kept count exceeds store depth")

    // The rate must be the floor of count * 16 / 5.
    `SWER_ASSERT_IMP(a_rate_match, aclk, aresetn, m_valid,
        (rate_x5 <= count_x16) && ((count_x16 - rate_x5) < (RATE_W+4)'(5)),
        "rate does not match kept count")

endmodule

bind sliding_window_event_rate swer_chk u_swer_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kept_count (m_kept_count),
    .m_rate_q4    (m_rate_q4),
    .m_overflow   (m_overflow)
);
